FILE: hw/rtl/tedet_pkg.sv
package tedet_pkg;

	// Control bytes
	localparam logic [7:0] CR_BYTE      = 8'h0D;
	localparam logic [7:0] ESC_RESET    = 8'h7E;
	localparam logic [7:0] CMD_EXIT_B   = 8'h2E; // '.'
	localparam logic [7:0] CMD_LIST_B   = 8'h23; // '#'
	localparam logic [7:0] CMD_SHELL_B  = 8'h43; // 'C'
	localparam logic [7:0] CMD_HELP_B   = 8'h3F; // '?'

	// Command codes
	localparam logic [1:0] ACT_EXIT  = 2'd0;
	localparam logic [1:0] ACT_LIST  = 2'd1;
	localparam logic [1:0] ACT_SHELL = 2'd2;
	localparam logic [1:0] ACT_HELP  = 2'd3;

	// Result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	localparam int MAX_TILDES_DEF = 4095;
	localparam int REPEAT_LIMIT   = 4095;
	localparam int QDEPTH_DEF     = 4;

	localparam int CNT_W  = 12;
	localparam int DATA_W = 24;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_CR     = 3'b010,
		MODE_HOLD   = 3'b100
	} mode_t;

	// One queued job: optional released escape run, then the main result
	typedef struct packed {
		logic             pre_valid;
		logic [7:0]       pre_byte;
		logic [CNT_W-1:0] pre_count;
		logic             main_kind;
		logic [7:0]       main_byte;
		logic [1:0]       main_action;
	} job_t;

	function automatic logic is_cmd(input logic [7:0] b);
		is_cmd = (b == CMD_EXIT_B) || (b == CMD_LIST_B) ||
			(b == CMD_SHELL_B) || (b == CMD_HELP_B);
	endfunction

	function automatic logic [1:0] cmd_code(input logic [7:0] b);
		case (b)
			CMD_EXIT_B:  cmd_code = ACT_EXIT;
			CMD_LIST_B:  cmd_code = ACT_LIST;
			CMD_SHELL_B: cmd_code = ACT_SHELL;
			CMD_HELP_B:  cmd_code = ACT_HELP;
			default:     cmd_code = ACT_EXIT;
		endcase
	endfunction

endpackage

FILE: hw/rtl/tedet_front.sv
module tedet_front #(
	parameter int MAX_TILDES = tedet_pkg::MAX_TILDES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic [7:0]          esc_byte,
	input  logic                q_full,
	output logic                in_ready,
	output logic                push,
	output tedet_pkg::job_t     job
);

	localparam int CAP_I = (MAX_TILDES < tedet_pkg::REPEAT_LIMIT) ?
		MAX_TILDES : tedet_pkg::REPEAT_LIMIT;
	localparam logic [tedet_pkg::CNT_W-1:0] CAP = tedet_pkg::CNT_W'(CAP_I);

	tedet_pkg::mode_t             mode_q, mode_d;
	logic [tedet_pkg::CNT_W-1:0]  cnt_q, cnt_d, rel;
	logic                         acc, bcmd;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign bcmd     = tedet_pkg::is_cmd(in_byte);

	// Classify the byte against the current mode
	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		push   = 1'b0;
		rel    = '0;
		job    = '0;
		job.main_kind = tedet_pkg::KIND_DATA;
		job.main_byte = in_byte;
		case (mode_q)
			tedet_pkg::MODE_CR: begin
				if (in_byte == esc_byte) begin
					mode_d = tedet_pkg::MODE_HOLD;
					cnt_d  = tedet_pkg::CNT_W'(1);
				end else begin
					push = acc;
					if (in_byte != tedet_pkg::CR_BYTE) begin
						mode_d = tedet_pkg::MODE_NORMAL;
						cnt_d  = '0;
					end
				end
			end
			tedet_pkg::MODE_HOLD: begin
				if (in_byte == esc_byte) begin
					if (cnt_q < CAP)
						cnt_d = cnt_q + tedet_pkg::CNT_W'(1);
				end else if (bcmd && cnt_q <= tedet_pkg::CNT_W'(1)) begin
					push            = acc;
					job.main_kind   = tedet_pkg::KIND_CMD;
					job.main_byte   = '0;
					job.main_action = tedet_pkg::cmd_code(in_byte);
					mode_d          = tedet_pkg::MODE_NORMAL;
					cnt_d           = '0;
				end else begin
					rel           = bcmd ? (cnt_q - tedet_pkg::CNT_W'(1)) : cnt_q;
					push          = acc;
					job.pre_valid = (rel != '0);
					job.pre_byte  = esc_byte;
					job.pre_count = rel;
					cnt_d         = '0;
					mode_d        = (in_byte == tedet_pkg::CR_BYTE) ?
						tedet_pkg::MODE_CR : tedet_pkg::MODE_NORMAL;
				end
			end
			default: begin
				push   = acc;
				cnt_d  = '0;
				mode_d = (in_byte == tedet_pkg::CR_BYTE) ?
					tedet_pkg::MODE_CR : tedet_pkg::MODE_NORMAL;
			end
		endcase
	end

	// Mode and held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tedet_pkg::MODE_NORMAL;
			cnt_q  <= '0;
		end else if (acc) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

FILE: hw/rtl/tedet_fifo.sv
module tedet_fifo #(
	parameter int DEPTH = tedet_pkg::QDEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tedet_pkg::job_t     wr_job,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output tedet_pkg::job_t     rd_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tedet_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_job    = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

FILE: hw/rtl/tedet_back.sv
module tedet_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  tedet_pkg::job_t               head,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tedet_pkg::DATA_W-1:0]  m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);

	logic                         valid_q, phase_q, load, take_pre;
	logic                         kind_q, last_q;
	logic [7:0]                   byte_q;
	logic [tedet_pkg::CNT_W-1:0]  rep_q;
	logic [1:0]                   act_q;

	assign load     = q_not_empty && (!valid_q || m_tready);
	assign take_pre = head.pre_valid && !phase_q;
	assign pop      = load && !take_pre;

	// Output register, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
			if (load)
				phase_q <= take_pre;
		end
	end

	// Output register, payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (take_pre) begin
				kind_q <= tedet_pkg::KIND_DATA;
				byte_q <= head.pre_byte;
				rep_q  <= head.pre_count;
				act_q  <= '0;
				last_q <= 1'b0;
			end else if (head.main_kind == tedet_pkg::KIND_CMD) begin
				kind_q <= tedet_pkg::KIND_CMD;
				byte_q <= '0;
				rep_q  <= '0;
				act_q  <= head.main_action;
				last_q <= 1'b1;
			end else begin
				kind_q <= tedet_pkg::KIND_DATA;
				byte_q <= head.main_byte;
				rep_q  <= tedet_pkg::CNT_W'(1);
				act_q  <= '0;
				last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, act_q, rep_q, byte_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

FILE: hw/rtl/terminal_escape_sequence_detector_core.sv
// Terminal escape sequence detector.
// Input stream s_*: one terminal byte per transfer in s_tdata[7:0].
// Output stream m_*: results; m_tuser is the kind (0 data run, 1 command),
// m_tdata carries out_byte, repeat count and command code, m_tlast marks the
// final result caused by an input byte. A byte yields zero, one or two results.
// cfg_we/cfg_wdata write the escape character (tilde after reset); write only
// while no transfer is in flight.
// Path: an accepted byte is written to the FIFO, then loaded into the output
// register, which drives m_tvalid; when a held run is released the byte
// itself follows the run as a separate result.
// Throughput: one input byte per cycle while the FIFO is not full; a byte
// that releases a held run takes one output transfer per result.
// Accepted bytes are classified at once by the front end and queued as jobs
// in a small FIFO (FIFO_DEPTH entries); s_tready drops only when it is full.
// When the receiver stalls, the output register holds its result and the
// FIFO absorbs further bytes until full.
// Reset clears mode, held count, FIFO and output valid, and restores the
// escape character to tilde.
module terminal_escape_sequence_detector_core #(
	parameter int MAX_TILDES = tedet_pkg::MAX_TILDES_DEF,
	parameter int FIFO_DEPTH = tedet_pkg::QDEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] in_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tedet_pkg::DATA_W-1:0]  m_tdata,   // [7:0] out_byte, [19:8] repeat_res,
	                                                 // [21:20] action, [23:22] zero
	output logic                          m_tuser,   // [0] kind
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_wdata
);

	logic [7:0]           esc_q;
	logic                 q_push, q_full;
	tedet_pkg::job_t      wr_job, head;
	logic                 pop, q_not_empty;

	// Escape character register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			esc_q <= tedet_pkg::ESC_RESET;
		else if (cfg_we)
			esc_q <= cfg_wdata;
	end

	tedet_front #(.MAX_TILDES(MAX_TILDES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.esc_byte (esc_q),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (q_push),
		.job      (wr_job)
	);

	tedet_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_job    (wr_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.rd_job    (head)
	);

	tedet_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

FILE: hw/rtl/tedet_checker.sv
module tedet_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tedet_pkg::DATA_W-1:0]  m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast
);

	// Stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
			$stable(m_tuser) && $stable(m_tlast))
		else $error("output changed while stalled");

	// A command is always the final result of its byte
	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("command result without last");

	// Command carries no byte and no count
	a_cmd_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[19:0] == 20'd0)
		else $error("command result with data fields");

	// Data run has a nonzero count and no command code
	a_run_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[19:8] != 12'd0 && m_tdata[21:20] == 2'd0)
		else $error("bad data run fields");

endmodule

bind terminal_escape_sequence_detector_core tedet_checker u_tedet_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
